[rtl/tscsn_pkg.sv]
// ----------------------------------------------------------------------------
// tscsn_pkg
// Types and codes shared by the two-step clock sync node.
// ----------------------------------------------------------------------------
package tscsn_pkg;

  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_START    = 4'd1;
  localparam logic [3:0] CMD_CHILD    = 4'd2;
  localparam logic [3:0] CMD_MACK     = 4'd3;
  localparam logic [3:0] CMD_SYNC     = 4'd4;
  localparam logic [3:0] CMD_FOLLOWUP = 4'd5;
  localparam logic [3:0] CMD_DREQ     = 4'd6;
  localparam logic [3:0] CMD_DRESP    = 4'd7;

  localparam logic [2:0] KIND_ANNOUNCE = 3'd0;
  localparam logic [2:0] KIND_MACK     = 3'd1;
  localparam logic [2:0] KIND_SYNC     = 3'd2;
  localparam logic [2:0] KIND_FOLLOWUP = 3'd3;
  localparam logic [2:0] KIND_DREQ     = 3'd4;
  localparam logic [2:0] KIND_DRESP    = 3'd5;
  localparam logic [2:0] KIND_OFFSET   = 3'd6;

  localparam logic [2:0] REG_OWN_ADDR  = 3'd0;
  localparam logic [2:0] REG_PARENT    = 3'd1;
  localparam logic [2:0] REG_RATE      = 3'd2;
  localparam logic [2:0] REG_PERIOD    = 3'd3;
  localparam logic [2:0] REG_SF_GAP    = 3'd4;
  localparam logic [2:0] REG_FD_GAP    = 3'd5;
  localparam logic [2:0] REG_FIRST     = 3'd6;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [15:0]        src_address;
    logic [15:0]        dest_address;
    logic signed [63:0] msg_timestamp;
    logic [62:0]        arrival_time;
  } tscsn_in_t;

  typedef struct packed {
    logic [2:0]         out_kind;
    logic [15:0]        out_src;
    logic [15:0]        out_dest;
    logic signed [63:0] out_timestamp;
    logic signed [63:0] measured_offset;
    logic signed [63:0] measured_delay;
    logic signed [63:0] local_time_now;
    logic               last;
  } tscsn_out_t;

endpackage

[rtl/two_step_clock_sync_node_core.sv]
// ----------------------------------------------------------------------------
// two_step_clock_sync_node_core
// Two-step sync tree node: local clock, child table, timers, offset math.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per message or tick, with its global arrival time.
//   out_* : zero or more result messages per request; last marks the final.
//   cfg_* : register writes (index, data); taken only while idle.
// Sequence:
//   A request passes a clock advance (two 32x32 partial products, then
//   accumulate) and a dispatch state before any result is produced. An
//   offset report adds a settle state so the clock correction lands first.
//   A sync or follow-up fan-out walks the child table memory entry by entry
//   (address, then registered data), plus a finishing step.
//   One request is in flight at a time; in_stall is high while busy.
// Reset: clears the clock, timers, child count and registers to defaults;
//   the child table is left as is (entries are written before being read).
// Stall: a result sits in the output register while out_stall is high and
//   the sequencer waits for it to drain before producing the next one.
// ----------------------------------------------------------------------------
module two_step_clock_sync_node_core
  import tscsn_pkg::*;
#(
  parameter int MAX_CHILDREN = 16,
  parameter int ADDR_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tscsn_in_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tscsn_out_t        out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);

  localparam int IW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int CW = $clog2(MAX_CHILDREN + 1);
  localparam logic [15:0] AMASK = 16'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_DISP  = 4'd3;
  localparam logic [3:0] ST_SYNCF = 4'd4;
  localparam logic [3:0] ST_FOLC  = 4'd5;
  localparam logic [3:0] ST_FOLF  = 4'd6;
  localparam logic [3:0] ST_DRQC  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;
  localparam logic [3:0] ST_OFF   = 4'd9;

  logic [3:0]  state_r;
  // configuration
  logic [15:0] own_r, parent_r;
  logic [31:0] rate_r, period_r, sfgap_r, fdgap_r;
  logic [62:0] first_r;
  // node state
  logic [63:0] clk_r, last_arr_r, sync_sent_r, sync_rx_r, mtx_r, dreq_sent_r;
  logic [63:0] sdl_r, fdl_r, ddl_r;
  logic [2:0]  armed_r;
  logic [15:0] master_r;
  logic [CW-1:0] used_r;
  // request
  tscsn_in_t   req_r;
  logic        neg_r;
  logic [63:0] mag_r, ph_r, pl_r;
  logic [CW-1:0] idx_r;
  logic        pend_r;     // memory read data valid for a fan-out result
  // output
  logic        ov_r;
  tscsn_out_t  od_r;
  // emit staging
  logic [2:0]  ek_r;
  logic [15:0] ed_r;
  logic [63:0] ets_r, eoff_r, edly_r;

  logic [15:0] ctab [MAX_CHILDREN];
  logic [15:0] crd_r;

  logic        acc_in, out_free, emit_go, fan_last;
  logic [62:0] now;
  logic [63:0] inc, a_v, b_v, slo, dlo, dly_v, off_v;
  logic        sa, sb, cy, bw, b64s, b64d;

  assign acc_in    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_free  = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign now       = req_r.arrival_time;
  assign emit_go   = out_free && ((state_r == ST_EMIT) ||
                     (pend_r && (state_r == ST_SYNCF || state_r == ST_FOLF)));
  // final fan-out entry is last unless a later check of this tick still fires
  assign fan_last  = (idx_r + CW'(1) == used_r) &&
                     !(armed_r[2] && ddl_r <= {1'b0, now}) &&
                     ((state_r == ST_FOLF) || !(armed_r[1] && fdl_r <= {1'b0, now}));

  always_comb begin
    inc = (ph_r << 2) + (pl_r >> 30);
    if (neg_r) inc = 64'd0 - inc;
    a_v  = sync_rx_r - mtx_r;
    b_v  = req_r.msg_timestamp - dreq_sent_r;
    sa   = a_v[63];
    sb   = b_v[63];
    slo  = a_v + b_v;
    cy   = slo < a_v;
    dlo  = a_v - b_v;
    bw   = a_v < b_v;
    b64s = sa ^ sb ^ cy;
    b64d = sa ^ sb ^ bw;
    dly_v = {b64s, slo[63:1]} + {63'd0, b64s & slo[0]};
    off_v = {b64d, dlo[63:1]} + {63'd0, b64d & dlo[0]};
  end

  // child table memory, registered read
  always_ff @(posedge clk) begin
    if (state_r == ST_DISP && req_r.cmd == CMD_CHILD &&
        (req_r.dest_address & AMASK) == (own_r & AMASK) &&
        used_r < CW'(MAX_CHILDREN))
      ctab[idx_r[IW-1:0]] <= req_r.src_address;
    crd_r <= ctab[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_go) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      own_r <= '0; parent_r <= '0;
      rate_r <= 32'd1073741824; period_r <= 32'd1000000;
      sfgap_r <= 32'd1000; fdgap_r <= 32'd1000; first_r <= 63'd5000;
      clk_r <= '0; last_arr_r <= '0; sync_sent_r <= '0; sync_rx_r <= '0;
      mtx_r <= '0; dreq_sent_r <= '0; sdl_r <= '0; fdl_r <= '0; ddl_r <= '0;
      armed_r <= '0; master_r <= '0; used_r <= '0;
      pend_r <= 1'b0; idx_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OWN_ADDR: own_r    <= cfg_wdata[15:0];
          REG_PARENT:   parent_r <= cfg_wdata[15:0];
          REG_RATE:     rate_r   <= cfg_wdata[31:0];
          REG_PERIOD:   period_r <= cfg_wdata[31:0];
          REG_SF_GAP:   sfgap_r  <= cfg_wdata[31:0];
          REG_FD_GAP:   fdgap_r  <= cfg_wdata[31:0];
          REG_FIRST:    first_r  <= cfg_wdata[62:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (acc_in) begin
          req_r   <= in_data;
          neg_r   <= {1'b0, in_data.arrival_time} < last_arr_r;
          mag_r   <= ({1'b0, in_data.arrival_time} < last_arr_r) ?
                     last_arr_r - {1'b0, in_data.arrival_time} :
                     {1'b0, in_data.arrival_time} - last_arr_r;
          idx_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          ph_r    <= mag_r[63:32] * rate_r;
          pl_r    <= mag_r[31:0] * rate_r;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          clk_r      <= clk_r + inc;
          last_arr_r <= {1'b0, now};
          idx_r      <= used_r;   // write slot for a child announce
          state_r    <= ST_DISP;
        end
        ST_DISP: begin
          if (req_r.cmd == CMD_TICK) begin
            idx_r <= '0;
            if (armed_r[0] && sdl_r <= {1'b0, now}) begin
              sync_sent_r <= clk_r;
              fdl_r   <= {1'b0, now} + 64'(sfgap_r);
              sdl_r   <= {1'b0, now} + 64'(period_r);
              armed_r <= armed_r | 3'b011;
              pend_r  <= 1'b0;
              state_r <= ST_SYNCF;
            end else state_r <= ST_FOLC;
          end else if (req_r.cmd == CMD_START) begin
            clk_r    <= '0;
            used_r   <= '0;
            master_r <= '0;
            sdl_r    <= {1'b0, first_r};
            armed_r  <= 3'b001;
            ek_r <= KIND_ANNOUNCE; ed_r <= parent_r; ets_r <= '0;
            eoff_r <= '0; edly_r <= '0;
            state_r <= ST_EMIT;
          end else if (req_r.cmd <= CMD_DRESP &&
                       (req_r.dest_address & AMASK) == (own_r & AMASK)) begin
            unique case (req_r.cmd)
              CMD_CHILD: begin
                if (used_r < CW'(MAX_CHILDREN)) used_r <= used_r + CW'(1);
                ek_r <= KIND_MACK; ed_r <= req_r.src_address; ets_r <= '0;
                eoff_r <= '0; edly_r <= '0;
                state_r <= ST_EMIT;
              end
              CMD_MACK: begin
                master_r <= req_r.src_address;
                state_r  <= ST_IDLE;
              end
              CMD_SYNC: begin
                sync_rx_r <= clk_r;
                state_r   <= ST_IDLE;
              end
              CMD_FOLLOWUP: begin
                mtx_r   <= req_r.msg_timestamp;
                ddl_r   <= {1'b0, now} + 64'(fdgap_r);
                armed_r <= armed_r | 3'b100;
                state_r <= ST_IDLE;
              end
              CMD_DREQ: begin
                ek_r <= KIND_DRESP; ed_r <= req_r.src_address; ets_r <= clk_r;
                eoff_r <= '0; edly_r <= '0;
                state_r <= ST_EMIT;
              end
              default: begin
                clk_r  <= clk_r - off_v;
                eoff_r <= off_v; edly_r <= dly_v; ets_r <= '0;
                ek_r <= KIND_OFFSET; ed_r <= '0; state_r <= ST_OFF;
              end
            endcase
          end else state_r <= ST_IDLE;
        end
        ST_OFF: state_r <= ST_EMIT;  // clock correction settles first
        ST_SYNCF, ST_FOLF: begin
          // walk child table: address idx_r read, data next cycle
          if (pend_r) begin
            if (out_free) begin
              od_r <= '{out_kind: (state_r == ST_SYNCF) ? KIND_SYNC : KIND_FOLLOWUP,
                        out_src: own_r & AMASK, out_dest: crd_r & AMASK,
                        out_timestamp: (state_r == ST_SYNCF) ? 64'd0 : sync_sent_r,
                        measured_offset: '0, measured_delay: '0,
                        local_time_now: clk_r, last: fan_last};
              pend_r <= 1'b0;
              idx_r  <= idx_r + CW'(1);
            end
          end else if (idx_r < used_r) begin
            pend_r <= 1'b1;
          end else begin
            idx_r   <= '0;
            state_r <= (state_r == ST_SYNCF) ? ST_FOLC : ST_DRQC;
          end
        end
        ST_FOLC: begin
          if (armed_r[1] && fdl_r <= {1'b0, now}) begin
            armed_r[1] <= 1'b0;
            pend_r  <= 1'b0;
            state_r <= ST_FOLF;
          end else state_r <= ST_DRQC;
        end
        ST_DRQC: begin
          if (armed_r[2] && ddl_r <= {1'b0, now}) begin
            armed_r[2]  <= 1'b0;
            dreq_sent_r <= clk_r;
            ek_r <= KIND_DREQ; ed_r <= master_r; ets_r <= '0;
            eoff_r <= '0; edly_r <= '0;
            state_r <= ST_EMIT;
          end else state_r <= ST_IDLE;
        end
        ST_EMIT: if (out_free) begin
          od_r <= '{out_kind: ek_r, out_src: own_r & AMASK, out_dest: ed_r & AMASK,
                    out_timestamp: ets_r, measured_offset: eoff_r,
                    measured_delay: edly_r, local_time_now: clk_r, last: 1'b1};
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !cfg_ready) else $error("cfg taken while busy");
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_CHILDREN)) else $error("child count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r) else $error("result lost under stall");
`endif

endmodule

[tb/sv/tscsn_checker.sv]
// ----------------------------------------------------------------------------
// tscsn_checker
// Watches the request, result and register channels of the sync node, keeps
// its own model of the node state and compares every result field by field.
// ----------------------------------------------------------------------------
module tscsn_checker
  import tscsn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  tscsn_in_t  in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  tscsn_out_t out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_wdata,
  output int         fail_count,
  output int         pending_count,
  output int         result_count,
  output int         offset_count
);

  localparam int MAX_KIDS = 16;

  logic [15:0] own_addr, parent_addr;
  logic [31:0] rate, period, sf_gap, fd_gap;
  logic [62:0] first_sync;

  logic [63:0] clk_local, prev_arrival, sync_tx, sync_rx, master_tx, dreq_tx;
  logic [63:0] sync_dl, fup_dl, dreq_dl;
  logic [15:0] master;
  logic [15:0] kids [MAX_KIDS];
  int          kid_cnt;
  logic [2:0]  armed;

  tscsn_out_t  expected_q [$];

  function automatic tscsn_out_t mk(logic [2:0] kind, logic [15:0] dest,
                                    logic [63:0] ts, logic [63:0] off,
                                    logic [63:0] dly);
    tscsn_out_t r;
    r.out_kind = kind; r.out_src = own_addr; r.out_dest = dest;
    r.out_timestamp = ts; r.measured_offset = off; r.measured_delay = dly;
    r.local_time_now = clk_local; r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_request(input tscsn_in_t req);
    logic [63:0]  now, mag, inc, a, b;
    logic [127:0] prod;
    logic signed [64:0] sum65, dif65;
    logic [63:0]  off, dly;
    tscsn_out_t   res [$];
    bit           neg;
    now  = {1'b0, req.arrival_time};
    neg  = now < prev_arrival;
    mag  = neg ? prev_arrival - now : now - prev_arrival;
    prod = 128'(mag) * 128'(rate);
    inc  = prod[93:30];
    if (neg) inc = -inc;
    clk_local    = clk_local + inc;
    prev_arrival = now;

    if (req.cmd == CMD_TICK) begin
      if (armed[0] && sync_dl <= now) begin
        sync_tx = clk_local;
        for (int i = 0; i < kid_cnt; i++)
          res.push_back(mk(KIND_SYNC, kids[i], 64'd0, 64'd0, 64'd0));
        fup_dl  = now + 64'(sf_gap);
        sync_dl = now + 64'(period);
        armed[1:0] = 2'b11;
      end
      if (armed[1] && fup_dl <= now) begin
        armed[1] = 1'b0;
        for (int i = 0; i < kid_cnt; i++)
          res.push_back(mk(KIND_FOLLOWUP, kids[i], sync_tx, 64'd0, 64'd0));
      end
      if (armed[2] && dreq_dl <= now) begin
        armed[2] = 1'b0;
        dreq_tx  = clk_local;
        res.push_back(mk(KIND_DREQ, master, 64'd0, 64'd0, 64'd0));
      end
    end else if (req.cmd == CMD_START) begin
      clk_local = '0; kid_cnt = 0; master = '0;
      sync_dl = {1'b0, first_sync}; armed = 3'b001;
      res.push_back(mk(KIND_ANNOUNCE, parent_addr, 64'd0, 64'd0, 64'd0));
    end else if (req.cmd <= CMD_DRESP && req.dest_address == own_addr) begin
      case (req.cmd)
        CMD_CHILD: begin
          if (kid_cnt < MAX_KIDS) begin
            kids[kid_cnt] = req.src_address;
            kid_cnt++;
          end
          res.push_back(mk(KIND_MACK, req.src_address, 64'd0, 64'd0, 64'd0));
        end
        CMD_MACK:     master = req.src_address;
        CMD_SYNC:     sync_rx = clk_local;
        CMD_FOLLOWUP: begin
          master_tx = req.msg_timestamp;
          dreq_dl   = now + 64'(fd_gap);
          armed[2]  = 1'b1;
        end
        CMD_DREQ: res.push_back(mk(KIND_DRESP, req.src_address, clk_local,
                                   64'd0, 64'd0));
        default: begin
          a = sync_rx - master_tx;
          b = req.msg_timestamp - dreq_tx;
          sum65 = $signed({a[63], a}) + $signed({b[63], b});
          dif65 = $signed({a[63], a}) - $signed({b[63], b});
          // divide truncates toward zero, matching the node
          sum65 = sum65 / 65'sd2;
          dif65 = dif65 / 65'sd2;
          dly = sum65[63:0];
          off = dif65[63:0];
          clk_local = clk_local - off;
          res.push_back(mk(KIND_OFFSET, 16'd0, 64'd0, off, dly));
        end
      endcase
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_q.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      own_addr <= '0; parent_addr <= '0; rate <= 32'd1073741824;
      period <= 32'd1000000; sf_gap <= 32'd1000; fd_gap <= 32'd1000;
      first_sync <= 63'd5000;
      clk_local = '0; prev_arrival = '0; master = '0; kid_cnt = 0;
      sync_tx = '0; sync_rx = '0; master_tx = '0; dreq_tx = '0;
      sync_dl = '0; fup_dl = '0; dreq_dl = '0; armed = '0;
      fail_count <= 0; result_count <= 0; offset_count <= 0;
      expected_q.delete();
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OWN_ADDR: own_addr    <= cfg_wdata[15:0];
          REG_PARENT:   parent_addr <= cfg_wdata[15:0];
          REG_RATE:     rate        <= cfg_wdata[31:0];
          REG_PERIOD:   period      <= cfg_wdata[31:0];
          REG_SF_GAP:   sf_gap      <= cfg_wdata[31:0];
          REG_FD_GAP:   fd_gap      <= cfg_wdata[31:0];
          REG_FIRST:    first_sync  <= cfg_wdata[62:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_request(in_data);
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (out_data.out_kind == KIND_OFFSET) offset_count <= offset_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else if (out_data !== expected_q[0]) begin
          $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                   $time, expected_q[0], out_data);
          fail_count <= fail_count + 1;
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      pending_count <= int'(expected_q.size());
    end
  end

endmodule

[tb/sv/tb_two_step_clock_sync_node_core.sv]
// ----------------------------------------------------------------------------
// tb_two_step_clock_sync_node_core
// Drives directed and random sync-tree traffic with register changes between
// phases, random bursts and stalls; a checker beside the node scores results.
// ----------------------------------------------------------------------------
module tb_two_step_clock_sync_node_core;
  import tscsn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  tscsn_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  tscsn_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  int fail_count, pending_count, result_count, offset_count;
  int cycle_count = 0;
  int req_count = 0;
  bit long_hold = 1'b0;

  logic [15:0] node_addr;
  logic [62:0] now_time;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_step_clock_sync_node_core u_top (.*);

  tscsn_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .fail_count, .pending_count, .result_count, .offset_count
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results still expected", pending_count);
      $display("tb_two_step_clock_sync_node_core: FAIL");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else begin
        mode = (cycle_count / 500) % 3;
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // one request; gap is idle cycles before it
  task automatic send(input logic [3:0] cmd, input logic [15:0] src,
                      input logic [15:0] dst, input logic [63:0] ts,
                      input logic [62:0] at, input int gap);
    tscsn_in_t r;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    r.cmd = cmd; r.src_address = src; r.dest_address = dst;
    r.msg_timestamp = ts; r.arrival_time = at;
    in_valid <= 1'b1; in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_count++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic step_time();
    case ($urandom_range(0, 9))
      0:       now_time = now_time - 63'($urandom_range(0, 3000));
      1:       now_time = now_time + 63'(rnd64());
      default: now_time = now_time + 63'($urandom_range(0, 4000));
    endcase
  endtask

  // well-formed session: start, children, master, sync exchange, ticks
  task automatic session(input int kids);
    int g;
    logic [15:0] m;
    send(CMD_START, 16'($urandom()), 16'($urandom()), rnd64(), now_time, 0);
    for (int i = 0; i < kids; i++) begin
      now_time += 63'($urandom_range(0, 500));
      send(CMD_CHILD, 16'($urandom()), node_addr, rnd64(), now_time,
           $urandom_range(0, 3));
    end
    m = 16'($urandom());
    send(CMD_MACK, m, node_addr, rnd64(), now_time, 0);
    for (int k = 0; k < 4; k++) begin
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
      now_time += 63'($urandom_range(500, 3000));
      send(CMD_TICK, 16'($urandom()), 16'($urandom()), rnd64(), now_time, g);
      send(CMD_SYNC, m, node_addr, rnd64(), now_time, g);
      now_time += 63'($urandom_range(0, 2000));
      send(CMD_FOLLOWUP, m, node_addr, rnd64(), now_time, g);
      now_time += 63'($urandom_range(0, 3000));
      send(CMD_TICK, 16'd0, 16'd0, 64'd0, now_time, g);
      send(CMD_DREQ, 16'($urandom()), node_addr, rnd64(), now_time, g);
      now_time += 63'($urandom_range(0, 2000));
      send(CMD_DRESP, m, node_addr,
           ($urandom_range(0, 3) == 0) ? rnd64() : {32'd0, $urandom()}, now_time, g);
    end
  endtask

  task automatic noise(input int n);
    logic [3:0] c;
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      step_time();
      c = 4'($urandom_range(0, 15));
      if (c == CMD_START && $urandom_range(0, 2) != 0) c = CMD_TICK;
      d = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : node_addr;
      send(c, 16'($urandom()), d, rnd64(), now_time,
           ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);
    end
  endtask

  initial begin
    node_addr = 16'h0000;
    now_time = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults, then extremes of fields
    send(CMD_TICK, 16'hFFFF, 16'hFFFF, 64'h8000_0000_0000_0000, 63'd100, 0);
    send(CMD_START, 16'h0000, 16'h0000, 64'h7FFF_FFFF_FFFF_FFFF, 63'd200, 0);
    send(CMD_CHILD, 16'hFFFF, 16'h0000, '0, 63'd300, 0);
    send(CMD_CHILD, 16'h0001, 16'h0000, '0, 63'd300, 0);
    send(CMD_CHILD, 16'h1234, 16'h0001, '0, 63'd300, 0);
    send(CMD_MACK, 16'hA5A5, 16'h0000, '0, 63'd400, 0);
    send(CMD_SYNC, 16'hA5A5, 16'h0000, '0, 63'd500, 0);
    send(CMD_TICK, 16'd0, 16'd0, '0, 63'd5000, 0);
    send(CMD_TICK, 16'd0, 16'd0, '0, 63'd6000, 0);
    send(CMD_FOLLOWUP, 16'hA5A5, 16'h0000, 64'h8000_0000_0000_0000, 63'd6100, 0);
    send(CMD_TICK, 16'd0, 16'd0, '0, 63'd7100, 0);
    send(CMD_DREQ, 16'h7777, 16'h0000, '0, 63'd7200, 0);
    send(CMD_DRESP, 16'hA5A5, 16'h0000, 64'h7FFF_FFFF_FFFF_FFFF, 63'd7300, 0);
    send(CMD_DRESP, 16'hA5A5, 16'h0000, 64'h8000_0000_0000_0001, 63'd7300, 0);
    send(4'd8, 16'd0, 16'd0, '0, 63'd7000, 0);
    send(4'd15, 16'hFFFF, 16'hFFFF, '1, 63'h7FFF_FFFF_FFFF_FFFF, 0);
    send(CMD_TICK, 16'd0, 16'd0, '0, 63'd0, 0);
    drain();

    // extremes of the registers, with many children past capacity
    node_addr = 16'hFFFF;
    write_reg(REG_OWN_ADDR, {48'd0, node_addr});
    write_reg(REG_PARENT, 64'hFFFF);
    write_reg(REG_RATE, 64'hFFFF_FFFF);
    write_reg(REG_PERIOD, 64'd1);
    write_reg(REG_SF_GAP, 64'd0);
    write_reg(REG_FD_GAP, 64'd0);
    write_reg(REG_FIRST, 64'd0);
    now_time = 63'd1000;
    session(18);
    long_hold = 1'b1;
    session(3);
    drain();

    write_reg(REG_RATE, 64'd0);
    write_reg(REG_PERIOD, 64'hFFFF_FFFF);
    write_reg(REG_SF_GAP, 64'hFFFF_FFFF);
    write_reg(REG_FD_GAP, 64'hFFFF_FFFF);
    write_reg(REG_FIRST, 64'h7FFF_FFFF_FFFF_FFFF);
    session(2);
    noise(10);
    drain();

    // random phases with mid-range settings
    for (int p = 0; p < 3; p++) begin
      node_addr = 16'($urandom());
      write_reg(REG_OWN_ADDR, {48'd0, node_addr});
      write_reg(REG_PARENT, {48'd0, 16'($urandom())});
      write_reg(REG_RATE, {32'd0, $urandom_range(32'h3000_0000, 32'h5000_0000)});
      write_reg(REG_PERIOD, 64'($urandom_range(1, 6000)));
      write_reg(REG_SF_GAP, 64'($urandom_range(0, 2000)));
      write_reg(REG_FD_GAP, 64'($urandom_range(0, 2000)));
      write_reg(REG_FIRST, {32'd0, now_time[31:0]} + 64'($urandom_range(0, 3000)));
      session($urandom_range(0, 6));
      noise(12);
      drain();
    end

    $display("covered %0d requests, %0d results checked, %0d offset reports",
             req_count, result_count, offset_count);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_two_step_clock_sync_node_core: PASS");
    else
      $display("tb_two_step_clock_sync_node_core: FAIL");
    $finish;
  end

endmodule

[two_step_clock_sync_node_core.f]
rtl/tscsn_pkg.sv
rtl/two_step_clock_sync_node_core.sv
tb/sv/tscsn_checker.sv
tb/sv/tb_two_step_clock_sync_node_core.sv
